// ===== design/vpf_pkg.sv =====
// Package for the video packet framer: payload and result types, frame
// constants, queue sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vpf_pkg;

    localparam int BUF_BYTES = 262144;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int CNT_W     = $clog2(BUF_BYTES + 1);
    localparam int HDR_LEN   = 16;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [15:0] SEQ_LAST  = 16'hFFFE;
    localparam logic [7:0]  CODE_TV   = 8'h11;
    localparam logic [7:0]  CODE_IR   = 8'h22;
    localparam logic [7:0]  PAD_BYTE  = 8'hFF;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_PULL = 1'b1
    } vpf_op_t;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_OVERSIZE = 2'd1,
        KIND_PAUSED   = 2'd2,
        KIND_BUSY     = 2'd3
    } vpf_kind_t;

    typedef struct packed {
        logic       op;
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       channel;
        logic       last;
    } vpf_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_last;
        logic [1:0] kind;
    } vpf_out_t;

    // result issued by the front; the byte comes from the store when from_mem
    typedef struct packed {
        vpf_out_t res;
        logic     from_mem;
    } vpf_cmd_t;

    typedef struct packed {
        logic full;
        logic almost_full;
    } vpf_qstat_t;

endpackage
`default_nettype wire

// ===== design/vpf_front.sv =====
// Front end: accepts items, keeps frame state and the payload store, and
// issues one result per transfer that produces one. Uses vpf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vpf_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire vpf_pkg::vpf_in_t   in_item,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data,
    input  wire vpf_pkg::vpf_qstat_t qstat,
    output logic                    push,
    output vpf_pkg::vpf_out_t       push_data
);

    logic [7:0] mem [vpf_pkg::BUF_BYTES];
    logic [7:0] mem_q;

    logic [vpf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [vpf_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [vpf_pkg::CNT_W-1:0] end_reg, end_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] seq_reg [2];
    logic [15:0] seq_next [2];
    logic        emitting_reg, emitting_next;
    logic        chan_reg, chan_next;
    logic        ovf_reg, ovf_next;
    logic        pause_reg;
    logic        s1_valid_reg, s1_valid_next;
    vpf_pkg::vpf_cmd_t s1_reg, s1_next;

    logic                       accept;
    logic                       store_ok;
    logic                       wr;
    logic [vpf_pkg::CNT_W-1:0]  cnt_new;
    logic                       ovf_new;
    logic [vpf_pkg::CNT_W:0]    big_sum;
    logic [vpf_pkg::CNT_W:0]    pay_end;
    logic [vpf_pkg::CNT_W:0]    frame_end_w;
    logic [vpf_pkg::CNT_W-1:0]  rd_off;
    logic [vpf_pkg::ADDR_W-1:0] rd_addr;
    logic [31:0]                size;
    logic [15:0]                seq_cur;
    logic [7:0]                 code;
    logic [7:0]                 hdr;
    logic [15:0]                seq_inc;

    assign accept   = in_valid && in_ready;
    assign in_ready = !qstat.full && !(s1_valid_reg && qstat.almost_full);

    assign store_ok = cnt_reg < vpf_pkg::CNT_W'(vpf_pkg::BUF_BYTES);
    assign wr       = accept && (in_item.op == vpf_pkg::OP_LOAD) && !emitting_reg
                      && in_item.has_byte && store_ok;
    assign cnt_new  = wr ? cnt_reg + 1'b1 : cnt_reg;
    assign ovf_new  = ovf_reg || (in_item.has_byte && !store_ok);
    assign big_sum  = {1'b0, cnt_new} + (vpf_pkg::CNT_W+1)'(32);
    assign frame_end_w = {1'b0, cnt_new} + (cnt_new[0] ? (vpf_pkg::CNT_W+1)'(30)
                                                         : (vpf_pkg::CNT_W+1)'(31));

    assign pay_end = {1'b0, cnt_reg} + (vpf_pkg::CNT_W+1)'(vpf_pkg::HDR_LEN);
    assign rd_off  = pos_reg - vpf_pkg::CNT_W'(vpf_pkg::HDR_LEN);
    assign rd_addr = rd_off[vpf_pkg::ADDR_W-1:0];
    assign size    = 32'(pay_end);
    assign seq_cur = seq_reg[chan_reg];
    assign code    = chan_reg ? vpf_pkg::CODE_IR : vpf_pkg::CODE_TV;
    assign seq_inc = (seq_reg[in_item.channel] == vpf_pkg::SEQ_LAST) ? 16'd0
                     : seq_reg[in_item.channel] + 16'd1;

    always_comb
    begin
        case (pos_reg[3:0])
            4'd3:    hdr = 8'h01;
            4'd4:    hdr = 8'h4E;
            4'd5:    hdr = 8'h01;
            4'd6:    hdr = size[7:0];
            4'd7:    hdr = size[15:8];
            4'd8:    hdr = size[23:16];
            4'd9:    hdr = size[31:24];
            4'd10:   hdr = code;
            4'd11:   hdr = code;
            4'd12:   hdr = seq_cur[7:0];
            4'd13:   hdr = seq_cur[15:8];
            4'd14:   hdr = 8'hAA;
            4'd15:   hdr = xor_reg;
            default: hdr = 8'h00;
        endcase
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        end_next      = end_reg;
        xor_next      = xor_reg;
        seq_next      = seq_reg;
        emitting_next = emitting_reg;
        chan_next     = chan_reg;
        ovf_next      = ovf_reg;
        s1_valid_next = 1'b0;
        s1_next       = '0;

        if (accept)
        begin
            if (in_item.op == vpf_pkg::OP_PULL)
            begin
                if (emitting_reg)
                begin
                    s1_valid_next      = 1'b1;
                    s1_next.res.kind   = vpf_pkg::KIND_BYTE;
                    s1_next.res.frame_last = (pos_reg == end_reg);
                    if (pos_reg < vpf_pkg::CNT_W'(vpf_pkg::HDR_LEN))
                        s1_next.res.out_byte = hdr;
                    else if ({1'b0, pos_reg} < pay_end)
                        s1_next.from_mem = 1'b1;
                    else
                        s1_next.res.out_byte = vpf_pkg::PAD_BYTE;
                    if (pos_reg == end_reg)
                    begin
                        cnt_next      = '0;
                        xor_next      = '0;
                        ovf_next      = 1'b0;
                        pos_next      = '0;
                        emitting_next = 1'b0;
                    end
                    else
                        pos_next = pos_reg + 1'b1;
                end
            end
            else if (emitting_reg)
            begin
                if (in_item.has_byte || in_item.last)
                begin
                    s1_valid_next    = 1'b1;
                    s1_next.res.kind = vpf_pkg::KIND_BUSY;
                end
            end
            else
            begin
                cnt_next = cnt_new;
                xor_next = wr ? xor_reg ^ in_item.payload_byte : xor_reg;
                ovf_next = ovf_new;
                if (in_item.last)
                begin
                    chan_next = in_item.channel;
                    if (ovf_new || cnt_new >= vpf_pkg::CNT_W'(vpf_pkg::BUF_BYTES))
                    begin
                        s1_valid_next    = 1'b1;
                        s1_next.res.kind = vpf_pkg::KIND_OVERSIZE;
                    end
                    else
                    begin
                        seq_next[in_item.channel] = seq_inc;
                        if (big_sum >= (vpf_pkg::CNT_W+1)'(vpf_pkg::BUF_BYTES))
                        begin
                            s1_valid_next    = 1'b1;
                            s1_next.res.kind = vpf_pkg::KIND_OVERSIZE;
                        end
                        else if (pause_reg)
                        begin
                            s1_valid_next    = 1'b1;
                            s1_next.res.kind = vpf_pkg::KIND_PAUSED;
                        end
                        else
                        begin
                            emitting_next = 1'b1;
                            pos_next      = '0;
                            end_next      = frame_end_w[vpf_pkg::CNT_W-1:0];
                        end
                    end
                    if (!emitting_next)
                    begin
                        cnt_next = '0;
                        xor_next = '0;
                        ovf_next = 1'b0;
                        pos_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            pos_reg      <= '0;
            end_reg      <= '0;
            xor_reg      <= '0;
            seq_reg[0]   <= '0;
            seq_reg[1]   <= '0;
            emitting_reg <= 1'b0;
            chan_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            pause_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            pos_reg      <= pos_next;
            end_reg      <= end_next;
            xor_reg      <= xor_next;
            seq_reg      <= seq_next;
            emitting_reg <= emitting_next;
            chan_reg     <= chan_next;
            ovf_reg      <= ovf_next;
            s1_valid_reg <= s1_valid_next;
            if (cfg_we)
                pause_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[cnt_reg[vpf_pkg::ADDR_W-1:0]] <= in_item.payload_byte;
        mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        push      = s1_valid_reg;
        push_data = s1_reg.res;
        if (s1_reg.from_mem)
            push_data.out_byte = mem_q;
    end

endmodule
`default_nettype wire

// ===== design/vpf_queue.sv =====
// Short result queue between the front end and the output stage.
// Uses vpf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vpf_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire vpf_pkg::vpf_out_t   push_data,
    input  wire logic                pop,
    output logic                     q_valid,
    output vpf_pkg::vpf_out_t        q_data,
    output vpf_pkg::vpf_qstat_t      qstat
);

    vpf_pkg::vpf_out_t entry_reg [vpf_pkg::QDEPTH];
    logic [vpf_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vpf_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [vpf_pkg::QCNT_W-1:0] count_reg, count_next;

    assign q_valid           = count_reg != '0;
    assign q_data            = entry_reg[rd_ptr_reg];
    assign qstat.full        = count_reg == vpf_pkg::QCNT_W'(vpf_pkg::QDEPTH);
    assign qstat.almost_full = count_reg >= vpf_pkg::QCNT_W'(vpf_pkg::QDEPTH - 1);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{(vpf_pkg::QCNT_W-1){1'b0}}, push}
                      - {{(vpf_pkg::QCNT_W-1){1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== design/vpf_back.sv =====
// Output stage: drains the result queue into the output register.
// Uses vpf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vpf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire vpf_pkg::vpf_out_t q_data,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output vpf_pkg::vpf_out_t      out_item
);

    logic              valid_reg, valid_next;
    vpf_pkg::vpf_out_t data_reg;

    assign pop        = q_valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_item   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= q_data;
    end

endmodule
`default_nettype wire

// ===== design/video_packet_framer_top.sv =====
// Video packet framer top level: front end, result queue, output stage.
// Uses vpf_pkg, vpf_front, vpf_queue, vpf_back.
//
// in_item carries load and pull requests (op, payload_byte, has_byte,
// channel, last); a transfer happens when in_valid and in_ready are high.
// out_item carries frame bytes and drop or busy notices (out_byte,
// frame_last, kind) under out_valid/out_ready.
// cfg_we/cfg_data write the pause bit.
// A result reaches out_item through the front register (with the payload store
// read), then the queue, then the output register. Throughput: one item per
// cycle while in_ready is high; the payload store takes a write and a read in
// the same cycle, so loads and pulls never wait on it.
// A four-entry queue decouples the front end from the output; when the
// receiver stalls, the queue fills and in_ready drops with room kept for the
// result already in flight. Items that give no result pass through the front
// end at one per cycle too, but only while in_ready is high.
// Reset clears counters, sequence numbers, pause and all valid flags; the
// payload store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module video_packet_framer_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire vpf_pkg::vpf_in_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output vpf_pkg::vpf_out_t      out_item,
    input  wire logic              cfg_we,
    input  wire logic              cfg_data
);

    logic                push;
    vpf_pkg::vpf_out_t   push_data;
    logic                pop;
    logic                q_valid;
    vpf_pkg::vpf_out_t   q_data;
    vpf_pkg::vpf_qstat_t qstat;

    vpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    vpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .qstat     (qstat)
    );

    vpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("result queue overflow");

    a_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.frame_last |-> out_item.kind == vpf_pkg::KIND_BYTE)
        else $error("frame_last on a notice");

    a_notice_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind != vpf_pkg::KIND_BYTE |-> out_item.out_byte == 8'h00)
        else $error("notice carries a byte");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !in_ready)
        else $error("input ready while queue full");

endmodule
`default_nettype wire
